[sv/nfss_pkg.sv]
// ----------------------------------------------------------------------------
// nfss_pkg
// Shared types and constants for the named file slot store.
// ----------------------------------------------------------------------------
package nfss_pkg;

    typedef enum logic [2:0] {
        ACT_CREATE = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_WRITE  = 3'd2,
        ACT_APPEND = 3'd3,
        ACT_DATA   = 3'd4,
        ACT_READ   = 3'd5,
        ACT_INFO   = 3'd6,
        ACT_NONE   = 3'd7
    } act_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_NAME = 3'd1,
        ST_EXISTS   = 3'd2,
        ST_NO_SPACE = 3'd3,
        ST_NOT_FND  = 3'd4,
        ST_TOO_BIG  = 3'd5,
        ST_BUSY     = 3'd6,
        ST_NO_XFER  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_READ
    } bk_state_t;

    // one classified command word handed from front to back
    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] name;
        logic        name_ok;
        logic [7:0]  count;
        logic [7:0]  data;
        logic [3:0]  rank;
    } cmd_t;

    // legal name character
    function automatic logic char_ok(input logic [7:0] c);
        char_ok = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                  (c >= 8'h30 && c <= 8'h39) || c == 8'h2E || c == 8'h5F ||
                  c == 8'h2D;
    endfunction

endpackage

[sv/nfss_front.sv]
// ----------------------------------------------------------------------------
// nfss_front
// Accept command words, canonicalise and check the name, queue them.
// ----------------------------------------------------------------------------
module nfss_front #(
    parameter int NAME_CHARS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    input  logic [63:0]       file_name,
    input  logic [7:0]        count_or_capacity,
    input  logic [7:0]        byte_in,
    input  logic [3:0]        file_rank,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output nfss_pkg::cmd_t    cmd
);

    nfss_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    nfss_pkg::cmd_t c_in;
    logic [63:0] canon;
    logic        term, bad;
    logic [3:0]  len;

    // build the canonical name and check it
    always_comb
    begin
        canon = '0;
        term  = 1'b0;
        bad   = 1'b0;
        len   = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (file_name[8*i +: 8] == 8'h00)
                term = 1'b1;
            if (!term)
            begin
                canon[8*i +: 8] = file_name[8*i +: 8];
                len = len + 4'd1;
                if (!nfss_pkg::char_ok(file_name[8*i +: 8]))
                    bad = 1'b1;
            end
        end
        c_in.action  = action;
        c_in.name    = canon;
        c_in.name_ok = !bad && len != 4'd0 && len <= 4'(NAME_CHARS) &&
                       canon != 64'h2E && canon != 64'h2E2E;
        c_in.count   = count_or_capacity;
        c_in.data    = byte_in;
        c_in.rank    = file_rank;
    end

    assign in_ready  = cnt_reg != 2'd2;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rp_reg];

    // store into the two-word queue
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            q_reg[wp_reg] <= c_in;
    end

    // advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                wp_reg <= !wp_reg;
            if (cmd_take)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(cmd_take);
        end
    end

endmodule

[sv/nfss_back.sv]
// ----------------------------------------------------------------------------
// nfss_back
// Carry out queued commands against the slot table and byte memory.
// ----------------------------------------------------------------------------
module nfss_back #(
    parameter int MAX_FILES  = 16,
    parameter int FILE_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  nfss_pkg::cmd_t    cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [7:0]        byte_out,
    output logic [5:0]        file_length,
    output logic [63:0]       info_name,
    output logic              last,
    output logic [4:0]        live_count
);

    localparam int SW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int BW = (FILE_BYTES > 1) ? $clog2(FILE_BYTES) : 1;
    localparam int LW = $clog2(FILE_BYTES + 1);
    localparam int CW = $clog2(MAX_FILES + 1);
    localparam int MD = MAX_FILES * FILE_BYTES;
    localparam int AW = $clog2(MD);

    logic [MAX_FILES-1:0] valid_reg, valid_next;
    logic [63:0]          name_mem [MAX_FILES];
    logic [LW-1:0]        len_reg [MAX_FILES];
    logic [7:0]           byte_mem [MD];
    logic [CW-1:0]        live_reg, live_next;
    logic [SW-1:0]        xslot_reg, xslot_next;
    logic [LW-1:0]        xpos_reg, xpos_next;
    logic [LW-1:0]        xleft_reg, xleft_next;
    nfss_pkg::bk_state_t  state_reg, state_next;
    logic [SW-1:0]        rslot_reg, rslot_next;
    logic [LW-1:0]        rpos_reg, rpos_next, rlen_reg, rlen_next;

    // output register
    logic       ov_reg, ov_next;
    logic [2:0] st_reg, st_next;
    logic [5:0] fl_reg, fl_next;
    logic [63:0] in_reg, in_next;
    logic       last_reg, last_next;
    logic       bsel_reg, bsel_next;
    logic [7:0] rd_reg;

    // match, free slot and rank search, all in parallel
    logic         hit, free_f, rank_f;
    logic [SW-1:0] hit_i, free_i, rank_i;
    logic [4:0]   seen;

    always_comb
    begin
        hit = 1'b0; hit_i = '0; free_f = 1'b0; free_i = '0;
        rank_f = 1'b0; rank_i = '0; seen = '0;
        for (int i = 0; i < MAX_FILES; i++)
        begin
            if (valid_reg[i] && name_mem[i] == cmd.name && !hit)
            begin
                hit = 1'b1; hit_i = SW'(i);
            end
            if (!valid_reg[i] && !free_f)
            begin
                free_f = 1'b1; free_i = SW'(i);
            end
            if (valid_reg[i])
            begin
                if (!rank_f && seen == {1'b0, cmd.rank})
                begin
                    rank_f = 1'b1; rank_i = SW'(i);
                end
                seen = seen + 5'd1;
            end
        end
    end

    logic          ob_free;
    logic          wr_en, mk_en, ln_en;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] ln_val;
    logic [SW-1:0] ln_slot;
    logic [LW-1:0] base;
    logic [8:0]    room;

    assign ob_free = !ov_reg || out_ready;

    // sequence commands and read bursts
    always_comb
    begin
        state_next = state_reg; valid_next = valid_reg; live_next = live_reg;
        xslot_next = xslot_reg; xpos_next = xpos_reg; xleft_next = xleft_reg;
        rslot_next = rslot_reg; rpos_next = rpos_reg; rlen_next = rlen_reg;
        ov_next = ov_reg && !out_ready; st_next = st_reg; fl_next = fl_reg;
        in_next = in_reg; last_next = last_reg; bsel_next = bsel_reg;
        cmd_take = 1'b0; wr_en = 1'b0; mk_en = 1'b0;
        ln_en = 1'b0; ln_val = '0; ln_slot = hit_i;
        wr_addr = AW'(xslot_reg) * AW'(FILE_BYTES) + AW'(xpos_reg);
        base = (cmd.action == nfss_pkg::ACT_APPEND) ? len_reg[hit_i] : '0;
        room = 9'(FILE_BYTES) - 9'(base);
        case (state_reg)
            nfss_pkg::BK_IDLE:
            begin
                if (cmd_valid && ob_free)
                begin
                    cmd_take = 1'b1;
                    ov_next = 1'b1; st_next = nfss_pkg::ST_OK; fl_next = '0;
                    in_next = '0; last_next = 1'b1; bsel_next = 1'b0;
                    if (cmd.action == nfss_pkg::ACT_DATA)
                    begin
                        if (xleft_reg == '0)
                            st_next = nfss_pkg::ST_NO_XFER;
                        else
                        begin
                            wr_en = 1'b1; ln_en = 1'b1; ln_slot = xslot_reg;
                            ln_val = xpos_reg + LW'(1);
                            xpos_next = xpos_reg + LW'(1);
                            xleft_next = xleft_reg - LW'(1);
                        end
                    end
                    else if (cmd.action == nfss_pkg::ACT_NONE)
                        st_next = nfss_pkg::ST_NO_XFER;
                    else if (xleft_reg != '0)
                        st_next = nfss_pkg::ST_BUSY;
                    else if (cmd.action == nfss_pkg::ACT_INFO)
                    begin
                        if (rank_f)
                        begin
                            fl_next = 6'(len_reg[rank_i]);
                            in_next = name_mem[rank_i];
                        end
                        else
                            st_next = nfss_pkg::ST_NOT_FND;
                    end
                    else if (!cmd.name_ok)
                        st_next = nfss_pkg::ST_BAD_NAME;
                    else if (cmd.action == nfss_pkg::ACT_CREATE)
                    begin
                        if (hit)
                            st_next = nfss_pkg::ST_EXISTS;
                        else if (!free_f)
                            st_next = nfss_pkg::ST_NO_SPACE;
                        else
                        begin
                            mk_en = 1'b1; ln_en = 1'b1; ln_slot = free_i;
                            valid_next[free_i] = 1'b1;
                            live_next = live_reg + CW'(1);
                        end
                    end
                    else if (!hit)
                        st_next = nfss_pkg::ST_NOT_FND;
                    else if (cmd.action == nfss_pkg::ACT_REMOVE)
                    begin
                        ln_en = 1'b1;
                        valid_next[hit_i] = 1'b0;
                        live_next = live_reg - CW'(1);
                    end
                    else if (cmd.action == nfss_pkg::ACT_WRITE ||
                             cmd.action == nfss_pkg::ACT_APPEND)
                    begin
                        if ({1'b0, cmd.count} > room)
                            st_next = nfss_pkg::ST_TOO_BIG;
                        else
                        begin
                            if (cmd.action == nfss_pkg::ACT_WRITE)
                                ln_en = 1'b1;
                            if (cmd.count != 8'd0)
                            begin
                                xslot_next = hit_i; xpos_next = base;
                                xleft_next = LW'(cmd.count);
                            end
                        end
                    end
                    else
                    begin
                        // read: check capacity, then stream bytes
                        if ({2'b0, cmd.count} < 10'(len_reg[hit_i]))
                            st_next = nfss_pkg::ST_TOO_BIG;
                        else if (len_reg[hit_i] != '0)
                        begin
                            ov_next = 1'b0;
                            rslot_next = hit_i; rpos_next = '0;
                            rlen_next = len_reg[hit_i];
                            state_next = nfss_pkg::BK_READ;
                        end
                    end
                end
            end
            nfss_pkg::BK_READ:
            begin
                // one byte a cycle while the output register is free; memory read is registered into rd_reg
                if (ob_free)
                begin
                    ov_next = 1'b1; st_next = nfss_pkg::ST_OK;
                    fl_next = 6'(rlen_reg); in_next = '0; bsel_next = 1'b1;
                    last_next = (rpos_reg + LW'(1)) == rlen_reg;
                    rpos_next = rpos_reg + LW'(1);
                    if (last_next)
                        state_next = nfss_pkg::BK_IDLE;
                end
            end
            default:
                state_next = nfss_pkg::BK_IDLE;
        endcase
    end

    logic [AW-1:0] rd_addr;
    assign rd_addr = AW'(rslot_reg) * AW'(FILE_BYTES) + AW'(rpos_reg[BW-1:0]);

    // byte and name memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
            byte_mem[wr_addr] <= cmd.data;
        if (state_reg == nfss_pkg::BK_READ && ob_free)
            rd_reg <= byte_mem[rd_addr];
        if (mk_en)
            name_mem[free_i] <= cmd.name;
        st_reg <= st_next; fl_reg <= fl_next; in_reg <= in_next;
        last_reg <= last_next; bsel_reg <= bsel_next;
        rslot_reg <= rslot_next; rpos_reg <= rpos_next; rlen_reg <= rlen_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfss_pkg::BK_IDLE;
            valid_reg <= '0; live_reg <= '0;
            xslot_reg <= '0; xpos_reg <= '0; xleft_reg <= '0;
            ov_reg <= 1'b0;
            for (int i = 0; i < MAX_FILES; i++)
                len_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next; valid_reg <= valid_next;
            live_reg <= live_next; xslot_reg <= xslot_next;
            xpos_reg <= xpos_next; xleft_reg <= xleft_next; ov_reg <= ov_next;
            if (ln_en)
                len_reg[ln_slot] <= ln_val;
        end
    end

    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign byte_out    = bsel_reg ? rd_reg : 8'd0;
    assign file_length = fl_reg;
    assign info_name   = in_reg;
    assign last        = last_reg;
    assign live_count  = 5'(live_reg);

endmodule

[sv/named_file_slot_store_core.sv]
// ----------------------------------------------------------------------------
// named_file_slot_store_core
// Table of named byte files driven by a command stream.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit first)                          | tuser | tlast
// s_axis  | in  | action, file_name, count_or_capacity, byte_in,  | -     | -
//         |     | file_rank (87 bits, padded to 88)               |       |
// m_axis  | out | status, byte_out, file_length, info_name,       | -     | last
//         |     | live_count (86 bits, padded to 88)              |       |
// A command's name is checked in the front as the command is accepted into the
// queue, and the executor, which searches all slots at once, takes it from
// there into the output register. A read registers each byte it fetches and
// gives one byte word a cycle, while the receiver is ready, from the byte memory's
// single port. Reset clears slot table and transfer state; no clearing pass.
// Either side may stall; a two-word queue between front and executor absorbs it.
// ----------------------------------------------------------------------------
module named_file_slot_store_core #(
    parameter int MAX_FILES  = 16,
    parameter int NAME_CHARS = 8,
    parameter int FILE_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action, file_name, count_or_capacity, byte_in, file_rank
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, byte_out, file_length, info_name, live_count
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic           cmd_valid, cmd_take;
    nfss_pkg::cmd_t cmd;
    logic [2:0]     status;
    logic [7:0]     byte_out;
    logic [5:0]     file_length;
    logic [63:0]    info_name;
    logic [4:0]     live_count;

    nfss_front #(.NAME_CHARS(NAME_CHARS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .action(s_axis_tdata[2:0]), .file_name(s_axis_tdata[66:3]),
        .count_or_capacity(s_axis_tdata[74:67]), .byte_in(s_axis_tdata[82:75]),
        .file_rank(s_axis_tdata[86:83]),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    nfss_back #(.MAX_FILES(MAX_FILES), .FILE_BYTES(FILE_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .status(status), .byte_out(byte_out), .file_length(file_length),
        .info_name(info_name), .last(m_axis_tlast), .live_count(live_count)
    );

    assign m_axis_tdata = {2'b0, live_count, info_name, file_length, byte_out, status};

`ifndef SYNTHESIS
    // a command is only taken when one is queued
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid) else $error("take from empty queue");
    // live count never exceeds the slot count
    a_live: assert property (@(posedge clk) disable iff (!rst_n)
        live_count <= 5'(MAX_FILES)) else $error("live count overflow");
    // an error word always ends its item
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status != nfss_pkg::ST_OK) |-> m_axis_tlast)
        else $error("error word without last");
`endif

endmodule

[sim/tb_named_file_slot_store_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_named_file_slot_store_core
// Self-checking bench for the named file slot store: a behavioural copy of
// the slot table predicts every result word, which is compared field by
// field with what the core returns. Directed tests cover names, errors,
// transfers, reads and info ranks; a random phase runs mostly well-formed
// create/write/append/read sequences with noise mixed in.
// ----------------------------------------------------------------------------
module tb_named_file_slot_store_core;

    localparam int NFILES = 16;
    localparam int NBYTES = 32;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  byte_out;
        logic [5:0]  file_length;
        logic [63:0] info_name;
        logic        last;
        logic [4:0]  live_count;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    // predicted slot table
    logic        tbl_valid [NFILES];
    logic [63:0] tbl_name  [NFILES];
    int          tbl_len   [NFILES];
    logic [7:0]  tbl_bytes [NFILES][NBYTES];
    int          live_files;
    int          open_slot;
    int          open_pos;
    int          open_left;

    result_t     expected_words[$];
    int          errors;
    bit          quiet;            // no stalls on either side
    logic [63:0] known_names[$];   // names used by well-formed sequences

    named_file_slot_store_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // queue one predicted word
    task automatic push_word(input logic [2:0] st, input logic [7:0] b, input int len,
                             input logic [63:0] nm, input logic lst);
        result_t r;
        r.status      = st;
        r.byte_out    = b;
        r.file_length = len[5:0];
        r.info_name   = nm;
        r.last        = lst;
        r.live_count  = live_files[4:0];
        expected_words.push_back(r);
    endtask

    // validate and canonicalise a raw name; returns 1 if legal
    function automatic bit name_legal(input logic [63:0] raw, output logic [63:0] canon);
        int          n;
        logic [7:0]  ch;
        canon = '0;
        n = 0;
        while (n < 8 && raw[8*n +: 8] != 8'h00) n++;
        for (int i = 0; i < n; i++)
        begin
            ch = raw[8*i +: 8];
            if (!((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
                  (ch >= "0" && ch <= "9") || ch == "." || ch == "_" || ch == "-"))
                return 0;
            canon[8*i +: 8] = ch;
        end
        if (n == 0) return 0;
        if (canon == 64'h2E || canon == 64'h2E2E) return 0;
        return 1;
    endfunction

    // predict the result words of one command
    task automatic predict_store(input nfss_pkg::act_t act, input logic [63:0] raw,
                                 input logic [7:0] cnt, input logic [7:0] din,
                                 input logic [3:0] rank);
        logic [63:0] nm;
        int          hit;
        int          seen;
        int          base;
        int          freei;
        hit = -1;
        if (act == nfss_pkg::ACT_DATA)
        begin
            if (open_left == 0)
                push_word(nfss_pkg::ST_NO_XFER, 0, 0, 0, 1);
            else
            begin
                tbl_bytes[open_slot][open_pos] = din;
                open_pos++;
                open_left--;
                tbl_len[open_slot] = open_pos;
                push_word(nfss_pkg::ST_OK, 0, 0, 0, 1);
            end
            return;
        end
        if (act == nfss_pkg::ACT_NONE)
        begin
            push_word(nfss_pkg::ST_NO_XFER, 0, 0, 0, 1);
            return;
        end
        if (open_left != 0)
        begin
            push_word(nfss_pkg::ST_BUSY, 0, 0, 0, 1);
            return;
        end
        if (act == nfss_pkg::ACT_INFO)
        begin
            seen = 0;
            for (int i = 0; i < NFILES; i++)
            begin
                if (!tbl_valid[i]) continue;
                if (seen == rank)
                begin
                    push_word(nfss_pkg::ST_OK, 0, tbl_len[i], tbl_name[i], 1);
                    return;
                end
                seen++;
            end
            push_word(nfss_pkg::ST_NOT_FND, 0, 0, 0, 1);
            return;
        end
        if (!name_legal(raw, nm))
        begin
            push_word(nfss_pkg::ST_BAD_NAME, 0, 0, 0, 1);
            return;
        end
        for (int i = NFILES - 1; i >= 0; i--)
            if (tbl_valid[i] && tbl_name[i] == nm) hit = i;
        if (act == nfss_pkg::ACT_CREATE)
        begin
            if (hit >= 0)
            begin
                push_word(nfss_pkg::ST_EXISTS, 0, 0, 0, 1);
                return;
            end
            freei = -1;
            for (int i = NFILES - 1; i >= 0; i--)
                if (!tbl_valid[i]) freei = i;
            if (freei < 0)
            begin
                push_word(nfss_pkg::ST_NO_SPACE, 0, 0, 0, 1);
                return;
            end
            tbl_valid[freei] = 1;
            tbl_name[freei]  = nm;
            tbl_len[freei]   = 0;
            live_files++;
            push_word(nfss_pkg::ST_OK, 0, 0, 0, 1);
            return;
        end
        if (hit < 0)
        begin
            push_word(nfss_pkg::ST_NOT_FND, 0, 0, 0, 1);
            return;
        end
        if (act == nfss_pkg::ACT_REMOVE)
        begin
            tbl_valid[hit] = 0;
            tbl_len[hit]   = 0;
            live_files--;
            push_word(nfss_pkg::ST_OK, 0, 0, 0, 1);
            return;
        end
        if (act == nfss_pkg::ACT_WRITE || act == nfss_pkg::ACT_APPEND)
        begin
            base = (act == nfss_pkg::ACT_WRITE) ? 0 : tbl_len[hit];
            if (int'(cnt) > NBYTES - base)
            begin
                push_word(nfss_pkg::ST_TOO_BIG, 0, 0, 0, 1);
                return;
            end
            if (act == nfss_pkg::ACT_WRITE) tbl_len[hit] = 0;
            if (cnt != 0)
            begin
                open_slot = hit;
                open_pos  = base;
                open_left = cnt;
            end
            push_word(nfss_pkg::ST_OK, 0, 0, 0, 1);
            return;
        end
        // read
        if (int'(cnt) < tbl_len[hit])
        begin
            push_word(nfss_pkg::ST_TOO_BIG, 0, 0, 0, 1);
            return;
        end
        if (tbl_len[hit] == 0)
        begin
            push_word(nfss_pkg::ST_OK, 0, 0, 0, 1);
            return;
        end
        for (int i = 0; i < tbl_len[hit]; i++)
            push_word(nfss_pkg::ST_OK, tbl_bytes[hit][i], tbl_len[hit], 0,
                      i + 1 == tbl_len[hit]);
    endtask

    // send one command word and predict its results
    task automatic send_cmd(input nfss_pkg::act_t act, input logic [63:0] nm,
                            input logic [7:0] cnt, input logic [7:0] din,
                            input logic [3:0] rank);
        // idle now and then
        if (!quiet && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 6);
        end
        s_axis_tdata  <= {1'b0, rank, din, cnt, nm, act};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_store(act, nm, cnt, din, rank);
    endtask

    // fill an open transfer with random bytes
    task automatic send_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_cmd(nfss_pkg::ACT_DATA, 0, 0, 8'($urandom_range(255)),
                     4'($urandom_range(15)));
    endtask

    // compare each returned word with the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tdata[2:0];
            got.byte_out = m_axis_tdata[10:3];
            got.file_length = m_axis_tdata[16:11];
            got.info_name = m_axis_tdata[80:17];
            got.live_count = m_axis_tdata[85:81];
            got.last = m_axis_tlast;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.status != want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.byte_out != want.byte_out)
                begin
                    $display("%0t: byte exp %h got %h", $time, want.byte_out, got.byte_out);
                    errors++;
                end
                if (got.file_length != want.file_length)
                begin
                    $display("%0t: length exp %0d got %0d", $time, want.file_length,
                             got.file_length);
                    errors++;
                end
                if (got.info_name != want.info_name)
                begin
                    $display("%0t: name exp %h got %h", $time, want.info_name, got.info_name);
                    errors++;
                end
                if (got.last != want.last)
                begin
                    $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
                    errors++;
                end
                if (got.live_count != want.live_count)
                begin
                    $display("%0t: live exp %0d got %0d", $time, want.live_count,
                             got.live_count);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);

    // random legal name of 1..8 characters
    function automatic logic [63:0] legal_name();
        logic [63:0] nm;
        string       cs;
        int          n;
        cs = "abcXYZ09._-";
        nm = '0;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) nm[8*i +: 8] = cs[$urandom_range(cs.len() - 1)];
        if (nm == 64'h2E || nm == 64'h2E2E) nm[7:0] = "f";
        return nm;
    endfunction

    task automatic test_names();
        send_cmd(nfss_pkg::ACT_CREATE, 64'h0, 0, 0, 0);                   // empty
        send_cmd(nfss_pkg::ACT_CREATE, 64'h2E, 0, 0, 0);                  // dot
        send_cmd(nfss_pkg::ACT_CREATE, 64'h2E2E, 0, 0, 0);                // dot dot
        send_cmd(nfss_pkg::ACT_CREATE, 64'h2E2E2E, 0, 0, 0);              // three dots is fine
        send_cmd(nfss_pkg::ACT_CREATE, 64'h0000_0000_0020_6161, 0, 0, 0); // space
        send_cmd(nfss_pkg::ACT_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
        send_cmd(nfss_pkg::ACT_CREATE, 64'h7A7A_7A7A_7A7A_7A7A, 0, 0, 0); // full length
        send_cmd(nfss_pkg::ACT_CREATE, 64'hFFFF_0061, 0, 0, 0);           // junk after end
        send_cmd(nfss_pkg::ACT_CREATE, 64'h61, 0, 0, 0);                  // exists
        send_cmd(nfss_pkg::ACT_REMOVE, 64'h62, 0, 0, 0);                  // not found
    endtask

    task automatic test_transfers();
        send_cmd(nfss_pkg::ACT_DATA, 0, 0, 8'hFF, 0);                     // no transfer
        send_cmd(nfss_pkg::ACT_NONE, 0, 0, 0, 0);
        send_cmd(nfss_pkg::ACT_WRITE, 64'h61, 33, 0, 0);                  // too large
        send_cmd(nfss_pkg::ACT_WRITE, 64'h61, 255, 0, 0);
        send_cmd(nfss_pkg::ACT_WRITE, 64'h61, 32, 0, 0);
        send_cmd(nfss_pkg::ACT_INFO, 0, 0, 0, 0);                         // busy
        send_bytes(32);
        send_cmd(nfss_pkg::ACT_APPEND, 64'h61, 1, 0, 0);                  // too large
        send_cmd(nfss_pkg::ACT_APPEND, 64'h61, 0, 0, 0);
        send_cmd(nfss_pkg::ACT_READ, 64'h61, 31, 0, 0);                   // capacity short
        send_cmd(nfss_pkg::ACT_READ, 64'h61, 255, 0, 0);
        send_cmd(nfss_pkg::ACT_WRITE, 64'h61, 0, 0, 0);                   // truncate
        send_cmd(nfss_pkg::ACT_READ, 64'h61, 0, 0, 0);                    // empty read
        send_cmd(nfss_pkg::ACT_INFO, 0, 0, 0, 0);
        send_cmd(nfss_pkg::ACT_INFO, 0, 0, 0, 4'hF);                      // past the live files
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 17; i++) send_cmd(nfss_pkg::ACT_CREATE, 64'h6161 + i, 0, 0, 0);
        send_cmd(nfss_pkg::ACT_INFO, 0, 0, 0, 4'hF);
        for (int i = 0; i < 17; i++) send_cmd(nfss_pkg::ACT_REMOVE, 64'h6161 + i, 0, 0, 0);
    endtask

    task automatic test_random(input int items);
        logic [63:0] nm;
        int          n;
        int          sent;
        sent = 0;
        while (sent < items)
        begin
            quiet = (sent > items / 2 && sent < items / 2 + 40);
            if (known_names.size() == 0 || $urandom_range(9) == 0)
            begin
                nm = legal_name();
                known_names.push_back(nm);
                if (known_names.size() > 12) void'(known_names.pop_front());
            end
            else
                nm = known_names[$urandom_range(known_names.size() - 1)];
            case ($urandom_range(9))
                0, 1: send_cmd(nfss_pkg::ACT_CREATE, nm, 0, 0, 0);
                2: send_cmd(nfss_pkg::ACT_REMOVE, nm, 0, 0, 0);
                3, 4:
                begin
                    n = $urandom_range(0, 6);
                    send_cmd($urandom_range(1) ? nfss_pkg::ACT_WRITE : nfss_pkg::ACT_APPEND,
                             nm, 8'(n), 0, 0);
                    if (open_left != 0) begin sent += open_left; send_bytes(open_left); end
                end
                5, 6: send_cmd(nfss_pkg::ACT_READ, nm,
                               $urandom_range(1) ? 8'd255 : 8'($urandom_range(40)), 0, 0);
                7: send_cmd(nfss_pkg::ACT_INFO, 0, 0, 0, 4'($urandom_range(15)));
                default: send_cmd(nfss_pkg::act_t'($urandom_range(7)), {$urandom, $urandom},
                                  8'($urandom_range(255)), 8'($urandom_range(255)),
                                  4'($urandom_range(15)));
            endcase
            sent++;
        end
        // close any transfer left open by noise
        if (open_left != 0) send_bytes(open_left);
        quiet = 0;
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        errors = 0;
        quiet = 0;
        live_files = 0;
        open_slot = 0;
        open_pos = 0;
        open_left = 0;
        for (int i = 0; i < NFILES; i++)
        begin
            tbl_valid[i] = 0;
            tbl_len[i] = 0;
            tbl_name[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_names();
        test_transfers();
        test_full_table();
        test_random(90);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
